// ===== rtl/sif_pkg.sv =====
// ----------------------------------------------------------------------------
// sif_pkg
// Types, codes and character helpers shared by the integer field scanner.
// ----------------------------------------------------------------------------
package sif_pkg;

  localparam int CNT_W       = 8;   // width and count fields
  localparam int CHAR_W      = 8;
  localparam int KIND_W      = 3;
  localparam int OUT_VALUE_W = 32;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 48;  // 43 payload bits padded to whole bytes
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int DIGIT_W     = 5;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int VALUE_BITS_DEF = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd2;

  // Conversion kinds.
  localparam logic [KIND_W-1:0] KIND_D = 3'd0;
  localparam logic [KIND_W-1:0] KIND_I = 3'd1;
  localparam logic [KIND_W-1:0] KIND_O = 3'd2;
  localparam logic [KIND_W-1:0] KIND_U = 3'd3;
  localparam logic [KIND_W-1:0] KIND_X = 3'd4;
  localparam logic [KIND_W-1:0] KIND_B = 3'd5;

  localparam logic [KIND_W-1:0]  KIND_RESET  = KIND_D;
  localparam logic [CNT_W-1:0]   WIDTH_RESET = 8'd128;

  // Characters of interest.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd31;

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_PREFIX = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    B_BIN = 2'd0,
    B_OCT = 2'd1,
    B_DEC = 2'd2,
    B_HEX = 2'd3
  } base_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] width_left;
    logic             negative;
    logic             overflow_seen;
    base_t            base;
    logic [CNT_W-1:0] taken;
  } sif_state_t;

  localparam sif_state_t STATE_CLEAR = '{
    phase:         PH_SKIP,
    width_left:    '0,
    negative:      1'b0,
    overflow_seen: 1'b0,
    base:          B_DEC,
    taken:         '0
  };

  typedef struct packed {
    logic                   char_consumed;
    logic [CNT_W-1:0]       chars_taken;
    logic                   overflowed;
    logic                   ok;
    logic [OUT_VALUE_W-1:0] value;
  } sif_result_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      d = DIGIT_W'(c - CH_A_LO + 8'd10);
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      d = DIGIT_W'(c - CH_A_UP + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [DIGIT_W-1:0] radix_of(input base_t b);
    logic [DIGIT_W-1:0] r;
    case (b)
      B_BIN:   r = 5'd2;
      B_OCT:   r = 5'd8;
      B_DEC:   r = 5'd10;
      default: r = 5'd16;
    endcase
    return r;
  endfunction

  // Base that a field starts with; kind i starts as hex so that 0x is seen.
  function automatic base_t kind_base(input logic [KIND_W-1:0] kind);
    base_t b;
    case (kind) inside
      KIND_I, KIND_X: b = B_HEX;
      KIND_O:         b = B_OCT;
      KIND_B:         b = B_BIN;
      default:        b = B_DEC;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/scan_integer_field_unit.sv =====
// ----------------------------------------------------------------------------
// scan_integer_field_unit
// Scanf-style integer field converter fed one character per request.
// ----------------------------------------------------------------------------
// Takes one character request per clock cycle, back to back. A request is
// held in an input register; the field step logic (one radix multiply-add
// and compare, then result formatting) then updates the field state from it
// and, when the field ends, loads the result register that drives out_tvalid.
// A waiting result does not stop the next request from entering the input
// register; only a full result register that is not being drained holds the
// input side back. Configuration writes are taken at any time, one per cycle,
// and should be made while no field is in progress.
module scan_integer_field_unit #(
  parameter int MAX_WIDTH  = sif_pkg::MAX_WIDTH_DEF,
  parameter int VALUE_BITS = sif_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: char_code[7:0]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sif_pkg::CHAR_W-1:0]     in_tdata,
  // tuser: end_of_input[0]
  input  logic [sif_pkg::IN_USER_W-1:0]  in_tuser,
  // tdata: value[31:0], ok[32], overflowed[33], chars_taken[41:34],
  //        char_consumed[42], zero[47:43]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sif_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sif_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sif_pkg::*;

  localparam int RES_W = $bits(sif_result_t);

  logic [KIND_W-1:0]     kind_r;
  logic [CNT_W-1:0]      width_r;
  logic                  short_r;

  logic                  in_valid_r;
  logic [CHAR_W-1:0]     in_char_r;
  logic                  in_eoi_r;

  sif_state_t            state_r;
  sif_state_t            state_nxt;
  logic [VALUE_BITS-1:0] mag_r;
  logic [VALUE_BITS-1:0] mag_nxt;

  logic                  out_valid_r;
  sif_result_t           out_res_r;

  logic                  advance;
  logic                  emit;
  sif_result_t           result;

  assign cfg_ready  = 1'b1;
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_res_r};

  sif_step #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .kind         (kind_r),
    .field_width  (width_r),
    .short_result (short_r),
    .char_code    (in_char_r),
    .end_of_input (in_eoi_r),
    .state_cur    (state_r),
    .mag_cur      (mag_r),
    .state_nxt    (state_nxt),
    .mag_nxt      (mag_nxt),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_RESET;
      width_r <= WIDTH_RESET;
      short_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KIND:  kind_r  <= cfg_data[KIND_W-1:0];
        CFG_WIDTH: width_r <= cfg_data;
        CFG_SHORT: short_r <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_eoi_r  <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
      mag_r   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      mag_r   <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= result;
    end
  end

endmodule

// ===== rtl/sif_step.sv =====
// ----------------------------------------------------------------------------
// sif_step
// Next-state and result logic for one character of an integer field.
// ----------------------------------------------------------------------------
module sif_step #(
  parameter int MAX_WIDTH  = sif_pkg::MAX_WIDTH_DEF,
  parameter int VALUE_BITS = sif_pkg::VALUE_BITS_DEF
) (
  input  logic [sif_pkg::KIND_W-1:0] kind,
  input  logic [sif_pkg::CNT_W-1:0]  field_width,
  input  logic                       short_result,
  input  logic [sif_pkg::CHAR_W-1:0] char_code,
  input  logic                       end_of_input,
  input  sif_pkg::sif_state_t        state_cur,
  input  logic [VALUE_BITS-1:0]      mag_cur,
  output sif_pkg::sif_state_t        state_nxt,
  output logic [VALUE_BITS-1:0]      mag_nxt,
  output logic                       emit,
  output sif_pkg::sif_result_t       result
);
  import sif_pkg::*;

  localparam int FULL_W = VALUE_BITS + 4;
  localparam int EXT_W  = (VALUE_BITS > OUT_VALUE_W) ? VALUE_BITS : OUT_VALUE_W;
  localparam logic [CNT_W-1:0]      MAX_W_C = CNT_W'(MAX_WIDTH);
  localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;
  localparam logic [VALUE_BITS-1:0] HALF = VALUE_BITS'(1) << (VALUE_BITS - 1);

  sif_state_t          st;
  logic [VALUE_BITS-1:0] mag;
  logic                done;
  logic                take;
  logic                consumed;
  logic [DIGIT_W-1:0]  dig;
  logic [FULL_W-1:0]   full;
  logic                signed_kind;
  logic                ovf;
  logic [VALUE_BITS-1:0] v;
  logic [EXT_W-1:0]    v_ext;
  logic [CNT_W-1:0]    wl;

  always_comb begin
    st       = state_cur;
    mag      = mag_cur;
    done     = 1'b0;
    take     = 1'b0;
    consumed = 1'b0;
    emit     = 1'b0;
    full     = '0;
    wl       = (field_width > MAX_W_C) ? MAX_W_C : field_width;
    dig      = digit_of(char_code);

    if (end_of_input) begin
      emit = 1'b1;
    end else begin
      if (st.phase == PH_SKIP) begin
        if (is_space(char_code)) begin
          done = 1'b1;
        end else begin
          st.width_left = wl;
          if (wl == '0) begin
            emit = 1'b1;
            done = 1'b1;
          end else begin
            st.base  = kind_base(kind);
            st.phase = PH_SIGN;
          end
        end
      end
      if (!done && st.phase == PH_SIGN) begin
        st.phase = PH_PREFIX;
        if (char_code == CH_PLUS || char_code == CH_MINUS) begin
          st.negative = (char_code == CH_MINUS);
          take = 1'b1;
          done = 1'b1;
        end
      end
      if (!done && st.phase == PH_PREFIX) begin
        if (st.base == B_HEX && char_code == CH_0) begin
          st.phase = PH_ZERO;
          take = 1'b1;
          done = 1'b1;
        end else begin
          if (kind == KIND_I) begin
            st.base = B_DEC;
          end
          st.phase = PH_DIGITS;
        end
      end
      if (!done && st.phase == PH_ZERO) begin
        st.phase = PH_DIGITS;
        if (char_code == CH_X_LO || char_code == CH_X_UP) begin
          take = 1'b1;
          done = 1'b1;
        end else if (kind == KIND_I) begin
          st.base = B_OCT;
        end
      end
      if (!done) begin
        if (dig >= radix_of(st.base)) begin
          emit = 1'b1;
        end else begin
          // Radix multiply as shifts; anything above the value width is overflow.
          case (st.base)
            B_BIN:   full = FULL_W'(mag) << 1;
            B_OCT:   full = FULL_W'(mag) << 3;
            B_DEC:   full = (FULL_W'(mag) << 3) + (FULL_W'(mag) << 1);
            default: full = FULL_W'(mag) << 4;
          endcase
          full = full + FULL_W'(dig);
          if (!st.overflow_seen) begin
            if (full[FULL_W-1:VALUE_BITS] != '0) begin
              st.overflow_seen = 1'b1;
              mag = ALL_ONES;
            end else begin
              mag = full[VALUE_BITS-1:0];
            end
          end
          take = 1'b1;
        end
      end
    end

    if (take) begin
      st.width_left = st.width_left - 1'b1;
      st.taken      = st.taken + 1'b1;
      if (st.width_left == '0) begin
        emit     = 1'b1;
        consumed = 1'b1;
      end
    end

    // Result formatting from the updated field state.
    signed_kind = (kind == KIND_D) || (kind == KIND_I);
    ovf = 1'b0;
    v   = '0;
    if (st.taken != '0) begin
      if (signed_kind) begin
        if (st.overflow_seen || mag > (st.negative ? HALF : HALF - 1'b1)) begin
          ovf = 1'b1;
          v   = st.negative ? HALF : HALF - 1'b1;
        end else begin
          v = st.negative ? (VALUE_BITS'(0) - mag) : mag;
        end
      end else if (st.overflow_seen) begin
        ovf = 1'b1;
        v   = ALL_ONES;
      end else begin
        v = st.negative ? (VALUE_BITS'(0) - mag) : mag;
      end
    end
    v_ext = EXT_W'(v);
    if (signed_kind && v[VALUE_BITS-1]) begin
      v_ext = v_ext | ~EXT_W'(ALL_ONES);
    end

    result.value         = v_ext[OUT_VALUE_W-1:0];
    if (short_result) begin
      result.value = {16'h0000, v_ext[15:0]};
    end
    result.ok            = (st.taken != '0);
    result.overflowed    = ovf;
    result.chars_taken   = st.taken;
    result.char_consumed = consumed;

    if (emit) begin
      state_nxt = STATE_CLEAR;
      mag_nxt   = '0;
    end else begin
      state_nxt = st;
      mag_nxt   = mag;
    end
  end

endmodule

// ===== tb/integer_field_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_check
// Watches the character, result and register channels of the integer field
// scanner. It keeps its own copy of the registers and of the field in
// progress, works out the result that each accepted character closes, and
// compares every accepted result field by field with the oldest one still
// waiting.
// ----------------------------------------------------------------------------
module integer_field_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [sif_pkg::CHAR_W-1:0]     in_tdata,
  input  logic [sif_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [sif_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sif_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import sif_pkg::*;

  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
  localparam int          NOT_A_DIGIT  = 16;
  localparam int          REPORT_LIMIT = 40;

  // Register copies.
  logic [KIND_W-1:0] kind_reg;
  logic [CNT_W-1:0]  width_reg;
  logic              trunc16;

  // Field in progress.
  phase_t            phase;
  logic [CNT_W-1:0]  width_left;
  logic [31:0]       magnitude;
  logic              negative;
  logic              overflow_seen;
  base_t             base;
  logic [CNT_W-1:0]  taken;

  sif_result_t expected_fields[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic int digit_value(input logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
    if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic int radix_for(input base_t b);
    case (b)
      B_BIN:   return 2;
      B_OCT:   return 8;
      B_DEC:   return 10;
      default: return 16;
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic clear_field();
    phase         = PH_SKIP;
    width_left    = '0;
    magnitude     = '0;
    negative      = 1'b0;
    overflow_seen = 1'b0;
    base          = B_DEC;
    taken         = '0;
  endtask

  // Signedness and truncation are taken from the registers as they stand now,
  // not as they stood when the field began.
  task automatic close_field(input logic consumed);
    sif_result_t r;
    logic [31:0] v;
    r = '0;
    v = '0;
    if (taken != 0) begin
      r.ok = 1'b1;
      if (kind_reg == KIND_D || kind_reg == KIND_I) begin
        if (overflow_seen || magnitude > (negative ? SIGN_BIT : SIGN_BIT - 1)) begin
          r.overflowed = 1'b1;
          v = negative ? SIGN_BIT : SIGN_BIT - 1;
        end else begin
          v = negative ? -magnitude : magnitude;
        end
      end else if (overflow_seen) begin
        r.overflowed = 1'b1;
        v = ALL_ONES;
      end else begin
        v = negative ? -magnitude : magnitude;
      end
      if (trunc16) v = {16'h0000, v[15:0]};
    end
    r.value         = v;
    r.chars_taken   = taken;
    r.char_consumed = consumed;
    expected_fields.push_back(r);
    clear_field();
  endtask

  task automatic count_char();
    width_left = width_left - 1'b1;
    taken      = taken + 1'b1;
    if (width_left == 0) close_field(1'b1);
  endtask

  task automatic scan_char(input logic [CHAR_W-1:0] c, input logic at_end);
    int d;
    int r;
    if (at_end) begin
      close_field(1'b0);
      return;
    end
    if (phase == PH_SKIP) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      width_left = (width_reg > MAX_WIDTH_DEF) ? CNT_W'(MAX_WIDTH_DEF) : width_reg;
      if (width_left == 0) begin
        close_field(1'b0);
        return;
      end
      // Kind i starts out as hex so that a 0x prefix can be recognized.
      case (kind_reg) inside
        KIND_I, KIND_X: base = B_HEX;
        KIND_O:         base = B_OCT;
        KIND_B:         base = B_BIN;
        default:        base = B_DEC;
      endcase
      phase = PH_SIGN;
    end
    if (phase == PH_SIGN) begin
      phase = PH_PREFIX;
      if (c == CH_PLUS || c == CH_MINUS) begin
        negative = (c == CH_MINUS);
        count_char();
        return;
      end
    end
    if (phase == PH_PREFIX) begin
      if (base == B_HEX && c == CH_0) begin
        phase = PH_ZERO;
        count_char();
        return;
      end
      if (kind_reg == KIND_I) base = B_DEC;
      phase = PH_DIGITS;
    end
    if (phase == PH_ZERO) begin
      phase = PH_DIGITS;
      if (c == CH_X_LO || c == CH_X_UP) begin
        count_char();
        return;
      end
      if (kind_reg == KIND_I) base = B_OCT;
    end
    r = radix_for(base);
    d = digit_value(c);
    if (d >= r) begin
      close_field(1'b0);
      return;
    end
    if (!overflow_seen) begin
      if (magnitude > (ALL_ONES - 32'(d)) / 32'(r)) begin
        overflow_seen = 1'b1;
        magnitude     = ALL_ONES;
      end else begin
        magnitude = magnitude * 32'(r) + 32'(d);
      end
    end
    count_char();
  endtask

  task automatic check_result(input sif_result_t got);
    sif_result_t want;
    if (expected_fields.size() == 0) begin
      report("unexpected result, value", got.value, '0);
      return;
    end
    want = expected_fields.pop_front();
    if (got.value != want.value) report("value", got.value, want.value);
    if (got.ok != want.ok) report("ok", got.ok, want.ok);
    if (got.overflowed != want.overflowed) report("overflowed", got.overflowed, want.overflowed);
    if (got.chars_taken != want.chars_taken) begin
      report("chars_taken", got.chars_taken, want.chars_taken);
    end
    if (got.char_consumed != want.char_consumed) begin
      report("char_consumed", got.char_consumed, want.char_consumed);
    end
  endtask

  // Results are checked before the request of the same edge is scanned, so a
  // stray result can never be matched by an expectation that is only now born.
  always @(posedge clk) begin
    if (!rst_n) begin
      kind_reg  = KIND_RESET;
      width_reg = WIDTH_RESET;
      trunc16   = 1'b0;
      clear_field();
      expected_fields.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(sif_result_t'(out_tdata[$bits(sif_result_t)-1:0]));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KIND:  kind_reg  = cfg_data[KIND_W-1:0];
          CFG_WIDTH: width_reg = cfg_data;
          CFG_SHORT: trunc16   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) scan_char(in_tdata, in_tuser[0]);
    end
    pending <= expected_fields.size();
  end

endmodule

// ===== tb/scan_integer_field_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_integer_field_unit_tb
// Feeds the integer field scanner with character streams: a short directed
// run over signs, prefixes, empty and cut-off fields, then random phases of
// numeric tokens, range edges and noise under changing register settings,
// with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module scan_integer_field_unit_tb;
  import sif_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;  // unused code, acts as u
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 160;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic              at_end;
    logic [CHAR_W-1:0] code;
  } stream_char_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  stream_char_t char_q[$];
  int           chars_queued = 0;
  bit           steady = 1'b0;
  int           stall_left = 0;
  int           cycle_count = 0;

  scan_integer_field_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  integer_field_check field_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: mostly ready, with stalls of random length now and then.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end
  end

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int dv);
    if (dv < 10) return CH_0 + CHAR_W'(dv);
    return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + CHAR_W'(dv - 10);
  endfunction

  function automatic logic [CNT_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return CNT_W'($urandom_range(1, 4));
      3:       return CNT_W'($urandom_range(5, 20));
      4:       return CNT_W'($urandom_range(129, 255));
      default: return CNT_W'(MAX_WIDTH_DEF);
    endcase
  endfunction

  task automatic push_byte(input logic [CHAR_W-1:0] c);
    char_q.push_back('{at_end: 1'b0, code: c});
    chars_queued++;
  endtask

  task automatic push_end();
    char_q.push_back('{at_end: 1'b1, code: CHAR_W'($urandom_range(0, 255))});
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // One field: blanks, then either noise or a sign, a prefix and digits that
  // mostly suit the kind, then a terminator of some sort.
  task automatic gen_field(input logic [KIND_W-1:0] kind);
    int          sel;
    int          radix;
    int          dv;
    logic [63:0] bound;
    string       digits;
    repeat ($urandom_range(0, 2)) push_byte(pick_blank());
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      repeat ($urandom_range(1, 4)) push_byte(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 3))
      0:       push_byte(CH_MINUS);
      1:       push_byte(CH_PLUS);
      default: ;
    endcase
    case (kind)
      KIND_O:  radix = 8;
      KIND_B:  radix = 2;
      KIND_X:  radix = 16;
      default: radix = 10;
    endcase
    if (kind == KIND_I || kind == KIND_X) begin
      case ($urandom_range(0, 3))
        0: begin
          push_text("0x");
          radix = 16;
        end
        1: begin
          push_text("0X");
          radix = 16;
        end
        2: begin
          if (kind == KIND_I) begin
            push_byte(CH_0);
            radix = 8;
          end
        end
        default: ;
      endcase
    end
    if (sel < 35) begin
      // Values at the edges of the signed, unsigned and short ranges.
      case ($urandom_range(0, 6))
        0:       bound = 64'd0;
        1:       bound = 64'hFFFF;
        2:       bound = 64'h7FFF_FFFF;
        3:       bound = 64'h8000_0000;
        4:       bound = 64'hFFFF_FFFF;
        5:       bound = 64'h1_0000_0000;
        default: bound = {$urandom, $urandom} >> $urandom_range(0, 40);
      endcase
      case (radix)
        2:       digits = $sformatf("%0b", bound);
        8:       digits = $sformatf("%0o", bound);
        16:      digits = $sformatf("%0h", bound);
        default: digits = $sformatf("%0d", bound);
      endcase
      push_text(digits);
    end else begin
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10)) begin
        dv = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(0, radix - 1);
        push_byte(digit_char(dv));
      end
    end
    case ($urandom_range(0, 5))
      0, 1:    push_byte(CH_SPACE);
      2:       push_end();
      3:       push_byte(CHAR_W'($urandom_range(0, 255)));
      4:       push_byte(pick_blank());
      default: ;
    endcase
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_settings(input logic [KIND_W-1:0] kind, input logic [CNT_W-1:0] width,
                                input logic trunc);
    put_reg(CFG_KIND, CFG_DATA_W'(kind));
    put_reg(CFG_WIDTH, width);
    put_reg(CFG_SHORT, CFG_DATA_W'(trunc));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_items();
    int burst;
    int gap;
    while (char_q.size() != 0) begin
      burst = steady ? 64 : $urandom_range(1, 12);
      while (burst != 0 && char_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= char_q[0].code;
        in_tuser  <= char_q[0].at_end;
        do @(posedge clk); while (!in_tready);
        void'(char_q.pop_front());
        burst--;
        if (!steady && $urandom_range(0, 299) == 0) begin
          // Hold back the next request until every result is out.
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0 && char_q.size() != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // A request that closes no field may still be in the pipeline when the last
  // result shows up, so settle waits on past it before registers are touched.
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [KIND_W-1:0] kind_now;
    logic [CNT_W-1:0]  width_now;
    logic              trunc_now;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a lone sign, a sign cut off by a stray letter, empty
    // fields, end of input while skipping blanks, then a field left open.
    push_byte(CH_TAB);
    push_text("-");
    push_end();
    push_text("+qq");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_end();
    push_text("-7");
    send_items();
    settle();
    // The open field is closed under an unsigned kind with 16-bit results.
    write_settings(KIND_SPARE, CNT_W'(MAX_WIDTH_DEF), 1'b1);
    push_end();
    send_items();
    settle();
    // Auto base: 0x with no digit after it, then an octal field.
    write_settings(KIND_I, 8'd255, 1'b0);
    push_text("0xg017 ");
    send_items();
    settle();
    write_settings(KIND_D, 8'd0, 1'b0);
    push_text("5 ");
    send_items();
    settle();
    // Width runs out in the middle of a hex field.
    write_settings(KIND_X, 8'd3, 1'b0);
    push_text("-abc");
    send_items();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          kind_now  = KIND_D;
          width_now = 8'd255;
          trunc_now = 1'b0;
        end
        1: begin
          kind_now  = KIND_SPARE;
          width_now = 8'd0;
          trunc_now = 1'b1;
        end
        2: begin
          kind_now  = KIND_B;
          width_now = 8'd1;
          trunc_now = 1'b0;
        end
        3: begin
          kind_now  = KIND_I;
          width_now = CNT_W'(MAX_WIDTH_DEF);
          trunc_now = 1'b1;
        end
        default: begin
          kind_now  = KIND_W'($urandom_range(0, 7));
          width_now = pick_width();
          trunc_now = 1'($urandom_range(0, 1));
        end
      endcase
      write_settings(kind_now, width_now, trunc_now);
      steady = (p % 4 == 2);
      chars_queued = 0;
      while (chars_queued < PHASE_ITEMS) gen_field(kind_now);
      send_items();
      settle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sif_pkg.sv
rtl/sif_step.sv
rtl/scan_integer_field_unit.sv
tb/integer_field_check.sv
tb/scan_integer_field_unit_tb.sv
